>>> hw/rtl/hfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfd_pkg: shared types and constants of the Huffman tree decoder
// Sequencer states, operation and error codes, and the result record that
// travels from the tree walker to the output stage.
// ----------------------------------------------------------------------------
package hfd_pkg;

    // fixed field widths of the item and result ports
    localparam int CODE_W     = 31;
    localparam int LEN_W      = 5;
    localparam int BYTE_W     = 8;
    localparam int BCNT_W     = 4;
    localparam int SYM_OUT_W  = 8;
    localparam int SYM_IN_W   = 8;

    // longest code that a load may carry
    localparam int MAX_CODE_LEN = 31;

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // error codes
    typedef logic [1:0] t_err;
    localparam t_err ERR_OK   = 2'd0;
    localparam t_err ERR_PATH = 2'd1;
    localparam t_err ERR_FULL = 2'd2;

    // walker sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_STEP,
        ST_LD_FETCH,
        ST_DC_STEP,
        ST_DC_NEXT,
        ST_ERR,
        ST_FLUSH
    } t_state;

    // one result handed to the output stage
    typedef struct packed {
        logic                 valid;
        logic [SYM_OUT_W-1:0] sym;
        t_err                 err;
        logic                 last;
    } t_result;

endpackage

>>> hw/rtl/hfd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfd_ram: generic simple dual-port RAM
// One write port and one read port per cycle, read data registered.
// ----------------------------------------------------------------------------
module hfd_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/hfd_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfd_out: result output register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module hfd_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hfd_pkg::t_result                i_push,
    output logic                            o_free,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [hfd_pkg::SYM_OUT_W-1:0]   o_symbol_out,
    output hfd_pkg::t_err                   o_error_code,
    output logic                            o_last
);

    logic                          r_valid;
    logic [hfd_pkg::SYM_OUT_W-1:0] r_sym;
    hfd_pkg::t_err                 r_err;
    logic                          r_last;

    // free when empty or being taken this cycle
    assign o_free = !r_valid || !i_stall;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_sym  <= i_push.sym;
            r_err  <= i_push.err;
            r_last <= i_push.last;
        end
    end

    assign o_valid      = r_valid;
    assign o_symbol_out = r_sym;
    assign o_error_code = r_err;
    assign o_last       = r_last;

endmodule

>>> hw/rtl/hfd_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfd_walk: tree walker and node allocator
// Steps through code bits and data bits one per step, reading the node table
// one dependent node at a time. The root node lives in flip-flops; all other
// nodes are in the node RAM and are written when allocated.
// ----------------------------------------------------------------------------
module hfd_walk #(
    parameter int NODE_COUNT   = 512,
    parameter int SYMBOL_WIDTH = 8
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    // item channel
    input  logic                                            i_valid,
    output logic                                            o_stall,
    input  logic                                            i_operation,
    input  logic [hfd_pkg::SYM_IN_W-1:0]                    i_symbol,
    input  logic [hfd_pkg::CODE_W-1:0]                      i_code_bits,
    input  logic [hfd_pkg::LEN_W-1:0]                       i_code_length,
    input  logic [hfd_pkg::BYTE_W-1:0]                      i_data_byte,
    input  logic [hfd_pkg::BCNT_W-1:0]                      i_bit_count,
    // result path
    output hfd_pkg::t_result                                o_res,
    input  logic                                            i_res_free,
    // node RAM
    output logic                                            o_wr_en,
    output logic [$clog2(NODE_COUNT)-1:0]                   o_wr_addr,
    output logic [2*$clog2(NODE_COUNT)+SYMBOL_WIDTH-1:0]    o_wr_data,
    output logic                                            o_rd_en,
    output logic [$clog2(NODE_COUNT)-1:0]                   o_rd_addr,
    input  logic [2*$clog2(NODE_COUNT)+SYMBOL_WIDTH-1:0]    i_rd_data
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int CNT_W = $clog2(NODE_COUNT + 1);
    localparam int SW    = SYMBOL_WIDTH;
    localparam int LEN_W = hfd_pkg::LEN_W;
    localparam logic [LEN_W:0] LEN_LIMIT = (LEN_W + 1)'(hfd_pkg::MAX_CODE_LEN);
    localparam logic [hfd_pkg::BCNT_W-1:0] BYTE_BITS = hfd_pkg::BCNT_W'(hfd_pkg::BYTE_W);

    hfd_pkg::t_state r_state, n_state;

    logic [SW-1:0]              r_sym, n_sym;
    logic [hfd_pkg::CODE_W-1:0] r_code, n_code;
    logic [LEN_W-1:0]           r_rem, n_rem;
    logic [hfd_pkg::BYTE_W-1:0] r_byte, n_byte;
    logic [hfd_pkg::BCNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0]           r_used, n_used;
    logic [IDX_W-1:0]           r_walk, n_walk;
    logic [IDX_W-1:0]           r_cur_idx, n_cur_idx;
    logic [IDX_W-1:0]           r_cur_left, n_cur_left;
    logic [IDX_W-1:0]           r_cur_right, n_cur_right;
    logic [SW-1:0]              r_cur_sym, n_cur_sym;
    logic [IDX_W-1:0]           r_root_left, n_root_left;
    logic [IDX_W-1:0]           r_root_right, n_root_right;
    hfd_pkg::t_err              r_err, n_err;
    logic                       r_pend_valid, n_pend_valid;
    logic [SW-1:0]              r_pend_sym, n_pend_sym;

    logic [IDX_W-1:0]  e_left, e_right;
    logic              code_bit;
    logic [IDX_W-1:0]  ld_slot, dc_next, new_idx;
    logic [IDX_W-1:0]  q_left, q_right;
    logic [SW-1:0]     q_sym;
    logic              q_leaf;
    logic              len_bad;
    logic              table_full;
    logic              pend_block;
    logic [SW+hfd_pkg::SYM_IN_W-1:0]  sym_in_ext;
    logic [SW+hfd_pkg::SYM_OUT_W-1:0] pend_out_ext;
    logic [hfd_pkg::SYM_OUT_W-1:0]    pend_out;
    logic              wb_go;
    logic [IDX_W-1:0]  wb_left, wb_right;
    logic [SW-1:0]     wb_sym;

    // current node view: the root comes from flip-flops
    assign e_left  = (r_cur_idx == '0) ? r_root_left  : r_cur_left;
    assign e_right = (r_cur_idx == '0) ? r_root_right : r_cur_right;

    // next code bit, first bit at position length minus one
    assign code_bit = r_code[r_rem - LEN_W'(1)];
    assign ld_slot  = code_bit ? e_right : e_left;
    assign dc_next  = r_byte[hfd_pkg::BYTE_W-1] ? e_right : e_left;
    assign new_idx  = r_used[IDX_W-1:0];

    // node RAM entry fields
    assign q_left  = i_rd_data[2*IDX_W+SW-1 -: IDX_W];
    assign q_right = i_rd_data[SW +: IDX_W];
    assign q_sym   = i_rd_data[SW-1:0];
    assign q_leaf  = (q_left == '0) && (q_right == '0);

    assign len_bad    = (i_code_length == '0) || ({1'b0, i_code_length} > LEN_LIMIT);
    assign table_full = (r_used == CNT_W'(NODE_COUNT));
    assign pend_block = r_pend_valid && !i_res_free;

    // symbol width conversions
    assign sym_in_ext   = {{SW{1'b0}}, i_symbol};
    assign pend_out_ext = {{hfd_pkg::SYM_OUT_W{1'b0}}, r_pend_sym};
    assign pend_out     = pend_out_ext[hfd_pkg::SYM_OUT_W-1:0];

    assign o_stall = (r_state != hfd_pkg::ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hfd_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_operation == hfd_pkg::OP_LOAD) begin
                        n_state = len_bad ? hfd_pkg::ST_IDLE : hfd_pkg::ST_LD_STEP;
                    end else begin
                        n_state = (r_walk == '0) ? hfd_pkg::ST_DC_STEP : hfd_pkg::ST_DC_NEXT;
                    end
                end
            end
            hfd_pkg::ST_LD_STEP: begin
                if (r_rem == '0) begin
                    n_state = hfd_pkg::ST_IDLE;
                end else if (ld_slot != '0) begin
                    n_state = hfd_pkg::ST_LD_FETCH;
                end else if (table_full) begin
                    n_state = hfd_pkg::ST_ERR;
                end
            end
            hfd_pkg::ST_LD_FETCH: begin
                n_state = hfd_pkg::ST_LD_STEP;
            end
            hfd_pkg::ST_DC_STEP: begin
                if (r_cnt == '0) begin
                    n_state = r_pend_valid ? hfd_pkg::ST_FLUSH : hfd_pkg::ST_IDLE;
                end else if (dc_next == '0) begin
                    n_state = hfd_pkg::ST_ERR;
                end else begin
                    n_state = hfd_pkg::ST_DC_NEXT;
                end
            end
            hfd_pkg::ST_DC_NEXT: begin
                if (!(q_leaf && pend_block)) begin
                    n_state = hfd_pkg::ST_DC_STEP;
                end
            end
            hfd_pkg::ST_ERR: begin
                if (i_res_free && !r_pend_valid) begin
                    n_state = hfd_pkg::ST_IDLE;
                end
            end
            hfd_pkg::ST_FLUSH: begin
                if (i_res_free) begin
                    n_state = hfd_pkg::ST_IDLE;
                end
            end
            default: n_state = hfd_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs per state
    always_comb begin
        n_sym        = r_sym;
        n_code       = r_code;
        n_rem        = r_rem;
        n_byte       = r_byte;
        n_cnt        = r_cnt;
        n_used       = r_used;
        n_walk       = r_walk;
        n_cur_idx    = r_cur_idx;
        n_cur_left   = r_cur_left;
        n_cur_right  = r_cur_right;
        n_cur_sym    = r_cur_sym;
        n_root_left  = r_root_left;
        n_root_right = r_root_right;
        n_err        = r_err;
        n_pend_valid = r_pend_valid;
        n_pend_sym   = r_pend_sym;
        o_rd_en      = 1'b0;
        o_rd_addr    = '0;
        o_res        = '0;
        wb_go        = 1'b0;
        wb_left      = e_left;
        wb_right     = e_right;
        wb_sym       = r_cur_sym;

        unique case (r_state)
            hfd_pkg::ST_IDLE: begin
                // capture the transaction
                if (i_valid) begin
                    n_sym  = sym_in_ext[SW-1:0];
                    n_code = i_code_bits;
                    n_rem  = i_code_length;
                    n_byte = i_data_byte;
                    n_cnt  = (i_bit_count > BYTE_BITS) ? BYTE_BITS : i_bit_count;
                    if (i_operation == hfd_pkg::OP_LOAD) begin
                        n_cur_idx = '0;
                    end else begin
                        n_cur_idx = r_walk;
                        o_rd_en   = (r_walk != '0);
                        o_rd_addr = r_walk;
                    end
                end
            end
            hfd_pkg::ST_LD_STEP: begin
                if (r_rem == '0) begin
                    // end of code: mark the final node
                    wb_go  = 1'b1;
                    wb_sym = r_sym;
                end else if (ld_slot != '0) begin
                    // existing child: store this node, fetch the child
                    wb_go     = 1'b1;
                    o_rd_en   = 1'b1;
                    o_rd_addr = ld_slot;
                    n_cur_idx = ld_slot;
                    n_rem     = r_rem - LEN_W'(1);
                end else if (table_full) begin
                    // abort, keep nodes made so far
                    wb_go = 1'b1;
                    n_err = hfd_pkg::ERR_FULL;
                end else begin
                    // allocate a cleared child and link it
                    wb_go       = 1'b1;
                    wb_left     = code_bit ? e_left : new_idx;
                    wb_right    = code_bit ? new_idx : e_right;
                    n_cur_idx   = new_idx;
                    n_cur_left  = '0;
                    n_cur_right = '0;
                    n_cur_sym   = '0;
                    n_used      = r_used + CNT_W'(1);
                    n_rem       = r_rem - LEN_W'(1);
                end
            end
            hfd_pkg::ST_LD_FETCH: begin
                n_cur_left  = q_left;
                n_cur_right = q_right;
                n_cur_sym   = q_sym;
            end
            hfd_pkg::ST_DC_STEP: begin
                if (r_cnt != '0) begin
                    if (dc_next == '0) begin
                        // missing child: drop the rest of the byte
                        n_err     = hfd_pkg::ERR_PATH;
                        n_walk    = '0;
                        n_cur_idx = '0;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = dc_next;
                        n_cur_idx = dc_next;
                        n_byte    = r_byte << 1;
                        n_cnt     = r_cnt - hfd_pkg::BCNT_W'(1);
                    end
                end
            end
            hfd_pkg::ST_DC_NEXT: begin
                if (q_leaf) begin
                    // leaf: older symbol goes out, this one waits for its last flag
                    if (!pend_block) begin
                        if (r_pend_valid) begin
                            o_res = '{valid: 1'b1, sym: pend_out,
                                      err: hfd_pkg::ERR_OK, last: 1'b0};
                        end
                        n_pend_valid = 1'b1;
                        n_pend_sym   = q_sym;
                        n_walk       = '0;
                        n_cur_idx    = '0;
                    end
                end else begin
                    n_cur_left  = q_left;
                    n_cur_right = q_right;
                    n_cur_sym   = q_sym;
                    n_walk      = r_cur_idx;
                end
            end
            hfd_pkg::ST_ERR: begin
                if (i_res_free) begin
                    if (r_pend_valid) begin
                        o_res = '{valid: 1'b1, sym: pend_out,
                                  err: hfd_pkg::ERR_OK, last: 1'b0};
                        n_pend_valid = 1'b0;
                    end else begin
                        o_res = '{valid: 1'b1, sym: '0, err: r_err, last: 1'b1};
                    end
                end
            end
            hfd_pkg::ST_FLUSH: begin
                if (i_res_free) begin
                    o_res = '{valid: 1'b1, sym: pend_out,
                              err: hfd_pkg::ERR_OK, last: 1'b1};
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
                n_cur_idx = '0;
            end
        endcase

        // write back the current node: root to flip-flops, others to RAM
        if (wb_go && (r_cur_idx == '0)) begin
            n_root_left  = wb_left;
            n_root_right = wb_right;
        end
    end

    assign o_wr_en   = wb_go && (r_cur_idx != '0);
    assign o_wr_addr = r_cur_idx;
    assign o_wr_data = {wb_left, wb_right, wb_sym};

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hfd_pkg::ST_IDLE;
            r_used       <= CNT_W'(1);
            r_walk       <= '0;
            r_root_left  <= '0;
            r_root_right <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_walk       <= n_walk;
            r_root_left  <= n_root_left;
            r_root_right <= n_root_right;
            r_pend_valid <= n_pend_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sym       <= n_sym;
        r_code      <= n_code;
        r_rem       <= n_rem;
        r_byte      <= n_byte;
        r_cnt       <= n_cnt;
        r_cur_idx   <= n_cur_idx;
        r_cur_left  <= n_cur_left;
        r_cur_right <= n_cur_right;
        r_cur_sym   <= n_cur_sym;
        r_err       <= n_err;
        r_pend_sym  <= n_pend_sym;
    end

endmodule

>>> hw/rtl/huffman_tree_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder: binary-tree Huffman code loader and decoder
// Builds a decode tree from symbol codes and decodes data bytes with it.
// ----------------------------------------------------------------------------
// One transaction at a time; o_stall is high while a transaction is worked
// on. A step into a node that already exists waits on the registered read of
// the node RAM. A load allocates each missing node of its code path, fetches
// each node already present and then stores the symbol; a load that runs out
// of nodes ends by handing out its error. A decode byte takes a step and a
// node read per bit and a closing step, after a re-read of the node when a
// walk carries over from the previous byte; a pending symbol is then handed
// out as the final result, and an error that follows a decoded symbol is
// handed out after that symbol. Downstream stalls can lengthen a transaction.
// Results leave through an output register, so a result waiting downstream
// only delays the next one. The node table needs no clearing pass after
// reset: the root is held in flip-flops and every other node is written when
// allocated.
// ----------------------------------------------------------------------------
module huffman_tree_decoder #(
    parameter int NODE_COUNT   = 512,
    parameter int SYMBOL_WIDTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_operation,
    input  logic [hfd_pkg::SYM_IN_W-1:0]        i_symbol,
    input  logic [hfd_pkg::CODE_W-1:0]          i_code_bits,
    input  logic [hfd_pkg::LEN_W-1:0]           i_code_length,
    input  logic [hfd_pkg::BYTE_W-1:0]          i_data_byte,
    input  logic [hfd_pkg::BCNT_W-1:0]          i_bit_count,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [hfd_pkg::SYM_OUT_W-1:0]       o_symbol_out,
    output logic [1:0]                          o_error_code,
    output logic                                o_last
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int ENT_W = 2 * IDX_W + SYMBOL_WIDTH;

    hfd_pkg::t_result res;
    logic             res_free;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [ENT_W-1:0] wr_data, rd_data;

    // tree walker
    hfd_walk #(
        .NODE_COUNT   (NODE_COUNT),
        .SYMBOL_WIDTH (SYMBOL_WIDTH)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .i_data_byte   (i_data_byte),
        .i_bit_count   (i_bit_count),
        .o_res         (res),
        .i_res_free    (res_free),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data)
    );

    // node table
    hfd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NODE_COUNT)
    ) u_nodes (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result register
    hfd_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (res),
        .o_free       (res_free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_symbol_out (o_symbol_out),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    // an accepted decode transaction always keeps the block busy next cycle
    a_decode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_operation == hfd_pkg::OP_DECODE)) |=> o_stall)
        else $error("decode transaction did not start");

    // error results carry symbol zero and close their transaction
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_error_code != hfd_pkg::ERR_OK)) |-> ((o_symbol_out == '0) && o_last))
        else $error("malformed error result");

    // a new result only comes out of work in progress
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result produced while idle");

endmodule
